// ===== hdl/bsa_pkg.sv =====
// Shared types and constants for the bitmap slot allocator.
// No dependencies; imported by bsa_ctrl, bsa_dp and bitmap_slot_allocator_core.
package bsa_pkg;

	localparam int OP_W     = 2;
	localparam int INDEX_W  = 10;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;

	// slot count after reset
	localparam int SLOT_COUNT_RST = 1024;

	// request opcodes
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_MARK  = 2'd2;
	localparam logic [OP_W-1:0] OP_INIT  = 2'd3;

	// response status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_MOD
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture request payload
		logic calc;    // word address / range check
		logic fetch;   // word memory read, bit offset
		logic commit;  // write back, load response
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free; // response register can take a new response
	} dp_sts_t;

endpackage

// ===== hdl/bsa_ctrl.sv =====
// Sequencer for the bitmap slot allocator: one request at a time through
// address, read and write-back steps. Depends on bsa_pkg.
module bsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output bsa_pkg::dp_cmd_t cmd,
	input  bsa_pkg::dp_sts_t sts
);
	import bsa_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DIV;
			end
			ST_DIV:  state_nxt = ST_READ;
			ST_READ: state_nxt = ST_MOD;
			ST_MOD: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV:  cmd.calc  = 1'b1;
			ST_READ: cmd.fetch = 1'b1;
			ST_MOD:  cmd.commit = sts.out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== hdl/bsa_dp.sv =====
// Datapath of the bitmap slot allocator: slot count register, word memory
// with valid and full summary bits, bit search and response register. Depends on bsa_pkg.
module bsa_dp #(
	parameter int MAX_SLOTS = 1024,
	parameter int WORD_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bsa_pkg::COUNT_W-1:0]    cfg_wdata,
	input  logic [bsa_pkg::OP_W-1:0]       op,
	input  logic [bsa_pkg::INDEX_W-1:0]    slot_index,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [bsa_pkg::STATUS_W-1:0]   status,
	output logic [bsa_pkg::INDEX_W-1:0]    granted_index,
	input  bsa_pkg::dp_cmd_t               cmd,
	output bsa_pkg::dp_sts_t               sts
);
	import bsa_pkg::*;

	localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int WAW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int UW         = $clog2(WORD_COUNT + 1);
	localparam int BW         = $clog2(WORD_BITS);
	// x / WORD_BITS = (x * RECIP) >> DIV_SH, exact for x below 4096
	localparam int DIV_SH     = 18;
	localparam int RECIP      = (2**DIV_SH + WORD_BITS - 1) / WORD_BITS;
	localparam int N0         = (MAX_SLOTS < SLOT_COUNT_RST) ? MAX_SLOTS : SLOT_COUNT_RST;
	localparam int USED0      = (N0 + WORD_BITS - 1) / WORD_BITS;
	localparam int LASTW0     = N0 / WORD_BITS;
	localparam int TAIL0      = N0 % WORD_BITS;
	localparam logic [WORD_BITS-1:0] PAT0 = (TAIL0 == 0) ? '0 :
		~((WORD_BITS'(1) << TAIL0) - WORD_BITS'(1));

	// configuration and derived word counts
	logic [COUNT_W-1:0]   cfg_q;
	logic [COUNT_W-1:0]   n_sat;
	logic [COUNT_W:0]     n_round;
	logic [31:0]          used_prod;
	logic [31:0]          last_prod;
	logic [31:0]          tail_calc;
	logic [UW-1:0]        used_q;
	logic [UW-1:0]        lastw_q;
	logic [BW-1:0]        tail_q;
	logic [WORD_BITS-1:0] tail_pat;

	// request and stage registers
	logic [OP_W-1:0]      op_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [31:0]          idx_prod;
	logic [WAW-1:0]       pick_w;
	logic                 pick_found;
	logic [WAW-1:0]       addr_s1;
	logic                 err_s1;
	logic                 found_s1;
	logic [31:0]          rem_calc;
	logic [BW-1:0]        rem_s2;
	logic [WORD_BITS-1:0] rdata_s2;
	logic                 rvld_s2;

	// map state
	logic [WORD_BITS-1:0] slot_mem [WORD_COUNT];
	logic [WORD_COUNT-1:0] valid_q;
	logic [WORD_COUNT-1:0] full_q;
	logic [UW-1:0]        form_word_q;
	logic [WORD_BITS-1:0] form_pat_q;

	// write-back step
	logic [WORD_BITS-1:0] cur_word;
	logic [WORD_BITS-1:0] new_word;
	logic [BW-1:0]        low_zero;
	logic [31:0]          gsum;
	logic                 is_alloc;
	logic                 is_slot_op;
	logic                 wr_en;
	logic                 do_init;
	logic [STATUS_W-1:0]  status_nxt;
	logic [INDEX_W-1:0]   granted_nxt;

	// response register
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [INDEX_W-1:0]   granted_q;

	assign n_sat     = (32'(cfg_q) > MAX_SLOTS) ? COUNT_W'(MAX_SLOTS) : cfg_q;
	assign n_round   = (COUNT_W + 1)'(n_sat) + (COUNT_W + 1)'(WORD_BITS - 1);
	assign used_prod = 32'(n_round) * 32'(RECIP);
	assign last_prod = 32'(n_sat) * 32'(RECIP);
	assign tail_calc = 32'(n_sat) - 32'(lastw_q) * 32'(WORD_BITS);
	assign tail_pat  = (tail_q == '0) ? '0 :
		~((WORD_BITS'(1) << tail_q) - WORD_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= COUNT_W'(SLOT_COUNT_RST);
			used_q  <= UW'(USED0);
			lastw_q <= UW'(LASTW0);
			tail_q  <= BW'(TAIL0);
		end else begin
			if (cfg_we) cfg_q <= cfg_wdata;
			used_q  <= used_prod[DIV_SH +: UW];
			lastw_q <= last_prod[DIV_SH +: UW];
			tail_q  <= tail_calc[BW-1:0];
		end
	end

	// first word with a free slot among the words in use
	always_comb begin
		pick_w     = '0;
		pick_found = 1'b0;
		for (int i = WORD_COUNT - 1; i >= 0; i--) begin
			if (!full_q[i] && (UW'(i) < used_q)) begin
				pick_w     = WAW'(i);
				pick_found = 1'b1;
			end
		end
	end

	assign idx_prod = 32'(idx_q) * 32'(RECIP);
	assign rem_calc = 32'(idx_q) - 32'(addr_s1) * 32'(WORD_BITS);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			idx_q <= slot_index;
		end
		if (cmd.calc) begin
			addr_s1  <= (op_q == OP_ALLOC) ? pick_w : idx_prod[DIV_SH +: WAW];
			err_s1   <= ({1'b0, idx_q} >= n_sat);
			found_s1 <= pick_found;
		end
		if (cmd.fetch) begin
			rem_s2   <= rem_calc[BW-1:0];
			rdata_s2 <= slot_mem[addr_s1];
			rvld_s2  <= valid_q[addr_s1];
		end
		if (wr_en) slot_mem[addr_s1] <= new_word;
	end

	// a word not written since the last initialize reads as its formed value
	assign cur_word = rvld_s2 ? rdata_s2 :
		((UW'(addr_s1) == form_word_q) ? form_pat_q : '0);

	always_comb begin
		low_zero = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!cur_word[b]) low_zero = BW'(b);
		end
	end

	assign is_alloc   = (op_q == OP_ALLOC);
	assign is_slot_op = (op_q == OP_FREE) || (op_q == OP_MARK);
	assign gsum       = 32'(addr_s1) * 32'(WORD_BITS) + 32'(low_zero);

	always_comb begin
		new_word    = cur_word;
		status_nxt  = STAT_OK;
		granted_nxt = '0;
		case (op_q)
			OP_ALLOC: begin
				new_word = cur_word | (WORD_BITS'(1) << low_zero);
				if (found_s1) begin
					granted_nxt = gsum[INDEX_W-1:0];
				end else begin
					status_nxt = STAT_FULL;
				end
			end
			OP_FREE: begin
				new_word = cur_word & ~(WORD_BITS'(1) << rem_s2);
				if (err_s1) status_nxt = STAT_RANGE;
			end
			OP_MARK: begin
				new_word = cur_word | (WORD_BITS'(1) << rem_s2);
				if (err_s1) status_nxt = STAT_RANGE;
			end
			default: begin
				new_word = cur_word;
			end
		endcase
	end

	assign wr_en   = cmd.commit && ((is_alloc && found_s1) || (is_slot_op && !err_s1));
	assign do_init = cmd.commit && (op_q == OP_INIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			full_q      <= '0;
			form_word_q <= UW'(LASTW0);
			form_pat_q  <= PAT0;
		end else if (do_init) begin
			valid_q     <= '0;
			full_q      <= '0;
			form_word_q <= lastw_q;
			form_pat_q  <= tail_pat;
		end else if (wr_en) begin
			valid_q[addr_s1] <= 1'b1;
			full_q[addr_s1]  <= &new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q  <= status_nxt;
			granted_q <= granted_nxt;
		end
	end

	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_index = granted_q;

endmodule

// ===== hdl/bitmap_slot_allocator_core.sv =====
// Each accepted request passes the ordered steps on the word memory (address and
// range check, registered read, write-back); write-back, which loads the response,
// waits while the response register is held. The next request is accepted after it.
// Reset: slot count 1024 and an empty map; word valid bits clear at once,
// so there is no clearing pass. Depends on bsa_pkg, bsa_ctrl, bsa_dp.
module bitmap_slot_allocator_core #(
	parameter int MAX_SLOTS = 1024,
	parameter int WORD_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bsa_pkg::COUNT_W-1:0]    cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bsa_pkg::OP_W-1:0]       op,
	input  logic [bsa_pkg::INDEX_W-1:0]    slot_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bsa_pkg::STATUS_W-1:0]   status,
	output logic [bsa_pkg::INDEX_W-1:0]    granted_index
);
	import bsa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	bsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	bsa_dp #(
		.MAX_SLOTS (MAX_SLOTS),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.op            (op),
		.slot_index    (slot_index),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.granted_index (granted_index),
		.cmd           (cmd),
		.sts           (sts)
	);

`ifndef NO_ASSERTIONS
	// one request in flight: no accept on the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// a request's response cannot appear on the cycle right after its accept
	a_no_early_resp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("response appeared too early");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK || status == STAT_FULL || status == STAT_RANGE))
		else $error("undefined status code");

	// only a successful allocate carries a slot number
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> granted_index == '0)
		else $error("slot number on a failed request");
`endif

endmodule

// ===== tb/tb_bitmap_slot_allocator_core.sv =====
// Self-checking testbench for bitmap_slot_allocator_core: a slot-map predictor,
// directed corner tests, then randomized traffic with random idling on both sides.
// Depends on bsa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_bitmap_slot_allocator_core;
	import bsa_pkg::*;

	localparam int MAX_SLOTS = 1024;
	localparam int WORD_BITS = 64;
	localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  granted;
	} slot_reply_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [COUNT_W-1:0]  cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     op;
	logic [INDEX_W-1:0]  slot_index;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  granted_index;

	// predicted block state
	logic [WORD_BITS-1:0] slot_map [WORD_COUNT];
	logic [COUNT_W-1:0]   slot_cnt;
	slot_reply_t          owed_replies [$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	int mismatch_count;

	bitmap_slot_allocator_core #(
		.MAX_SLOTS(MAX_SLOTS),
		.WORD_BITS(WORD_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.slot_index(slot_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.granted_index(granted_index)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int live_slots();
		return (slot_cnt > MAX_SLOTS) ? MAX_SLOTS : int'(slot_cnt);
	endfunction

	// clear the map, tail bits past the count in the last word read as used
	function automatic void reform_map();
		int live;
		int tail;
		live = live_slots();
		tail = live % WORD_BITS;
		foreach (slot_map[w])
			slot_map[w] = '0;
		if (tail != 0)
			slot_map[live / WORD_BITS] = ~((64'd1 << tail) - 64'd1);
	endfunction

	function automatic slot_reply_t apply_slot_request(input logic [OP_W-1:0] o,
			input logic [INDEX_W-1:0] idx);
		slot_reply_t r;
		int live;
		int used;
		bit found;
		live = live_slots();
		r.status = STAT_OK;
		r.granted = '0;
		case (o)
			OP_ALLOC: begin
				used = (live + WORD_BITS - 1) / WORD_BITS;
				found = 1'b0;
				for (int w = 0; w < used && !found; w++)
					for (int b = 0; b < WORD_BITS && !found; b++)
						if (!slot_map[w][b]) begin
							slot_map[w][b] = 1'b1;
							r.granted = INDEX_W'(w * WORD_BITS + b);
							found = 1'b1;
						end
				if (!found)
					r.status = STAT_FULL;
			end
			OP_FREE, OP_MARK: begin
				if (idx >= live)
					r.status = STAT_RANGE;
				else
					slot_map[idx / WORD_BITS][idx % WORD_BITS] = (o == OP_MARK);
			end
			default: reform_map();
		endcase
		return r;
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index();
		int live;
		live = live_slots();
		if (live > 0 && $urandom_range(99) < 75)
			return INDEX_W'($urandom_range(live - 1));
		return INDEX_W'($urandom_range(MAX_SLOTS - 1));
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_request(input logic [OP_W-1:0] o, input logic [INDEX_W-1:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		slot_index <= idx;
		do @(posedge clk); while (!in_ready);
		owed_replies.push_back(apply_slot_request(o, idx));
	endtask

	task automatic send_random_request();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			send_request(OP_ALLOC, INDEX_W'($urandom_range(MAX_SLOTS - 1)));
		else if (roll < 80)
			send_request(OP_FREE, pick_index());
		else if (roll < 97)
			send_request(OP_MARK, pick_index());
		else
			send_request(OP_INIT, INDEX_W'($urandom_range(MAX_SLOTS - 1)));
	endtask

	// drop valid, drain every owed reply, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_slot_count(input logic [COUNT_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		slot_cnt = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : reply_check
		slot_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_replies.size() == 0) begin
				report_mismatch("reply with no request outstanding", status, 0);
			end else begin
				want = owed_replies.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (granted_index !== want.granted)
					report_mismatch("granted_index", granted_index, want.granted);
			end
		end
	end

	// full-size map right after reset
	task automatic test_reset_defaults();
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '1);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, 10'd1);
		send_request(OP_ALLOC, '0);
		send_request(OP_MARK, 10'd1023);
		send_request(OP_FREE, 10'd1023);
		send_request(OP_FREE, 10'd0);
		send_request(OP_INIT, '1);
	endtask

	// one slot: tail bits block the rest of word 0, map fills at once
	task automatic test_tiny_map();
		write_slot_count(11'd1);
		send_request(OP_INIT, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, 10'd1);
		send_request(OP_MARK, 10'd1023);
		send_request(OP_FREE, 10'd0);
		send_request(OP_ALLOC, '0);
	endtask

	// raising the count without init keeps the old tail bits
	task automatic test_stale_map_after_write();
		write_slot_count(11'd64);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, 10'd5);
		send_request(OP_ALLOC, '0);
	endtask

	// zero count, then a count above the maximum that saturates
	task automatic test_count_bounds();
		write_slot_count(11'd0);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, 10'd0);
		send_request(OP_MARK, 10'd0);
		send_request(OP_INIT, '0);
		write_slot_count(11'd2047);
		send_request(OP_INIT, '0);
		send_request(OP_MARK, 10'd1023);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, 10'd1023);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int chunks);
		int roll;
		logic [COUNT_W-1:0] cnt;
		for (int c = 0; c < chunks; c++) begin
			roll = $urandom_range(99);
			if (roll < 10)
				cnt = 11'd1024;
			else if (roll < 15)
				cnt = 11'd2047;
			else if (roll < 19)
				cnt = 11'd0;
			else if (roll < 29)
				cnt = 11'd64;
			else
				cnt = COUNT_W'($urandom_range(1, 160));
			write_slot_count(cnt);
			send_idle_pct = idle_pct;
			recv_stall_pct = stall_pct;
			// mostly start from a clean map; sometimes keep the stale one
			if ($urandom_range(9) != 0)
				send_request(OP_INIT, INDEX_W'($urandom_range(MAX_SLOTS - 1)));
			repeat (100) send_random_request();
		end
	endtask

	// receiver holds off long enough for the block to back up its input
	task automatic test_output_stall();
		write_slot_count(11'd200);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_request(OP_INIT, '0);
		@(posedge clk);
		hold_cycles = 300;
		repeat (40) send_random_request();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = OP_ALLOC;
		slot_index = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		mismatch_count = 0;
		slot_cnt = COUNT_W'(SLOT_COUNT_RST);
		reform_map();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_tiny_map();
		test_stale_map_after_write();
		test_count_bounds();
		test_random_traffic(0, 0, 4);
		test_random_traffic(50, 0, 4);
		test_random_traffic(0, 50, 4);
		test_random_traffic(27, 27, 4);
		test_output_stall();

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_bitmap_slot_allocator_core: done, clean");
		else
			$display("tb_bitmap_slot_allocator_core: done, errors");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb_bitmap_slot_allocator_core: done, errors");
		$finish;
	end

endmodule
